FILE: design/arithmetic_encoder_core_macros.svh
// Assertion macros for the arithmetic encoder core RTL.
// Used by files that include this header; expects i_clk and i_rst_n in scope.
`ifndef ARITHMETIC_ENCODER_CORE_MACROS_SVH
`define ARITHMETIC_ENCODER_CORE_MACROS_SVH

// Property that must hold in the same cycle.
`define ARENC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Implication checked on the following cycle.
`define ARENC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/arenc_pkg.sv
// Package for the arithmetic encoder core: constants, types and the renormalize classifier.
// No dependencies.
package arenc_pkg;

    localparam int FREQ_BITS   = 16;
    localparam int PENDING_MAX = 448;
    localparam int PEND_W      = 9;
    localparam int PROD_W      = 49;
    localparam int DIV_STEPS   = 49;
    localparam int DCNT_W      = 6;
    localparam int RCNT_W      = 7;

    localparam logic [31:0] HALF_MARK     = 32'h8000_0000;
    localparam logic [31:0] QUARTER_MARK  = 32'h4000_0000;
    localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;
    localparam logic [31:0] FULL_TOP      = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STEP_ZERO,
        STEP_ONE,
        STEP_MID,
        STEP_STOP
    } t_step;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL_HI,
        CMD_MUL_LO,
        CMD_DIV_STEP,
        CMD_SET_IV,
        CMD_SCAN_STEP,
        CMD_REN_INIT,
        CMD_REN_STEP,
        CMD_PUSH,
        CMD_FIN_ADD,
        CMD_PAD,
        CMD_FIN_INIT,
        CMD_DRAIN
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_HI,
        S_DIV_LO,
        S_SCAN,
        S_REN,
        S_EMIT,
        S_FIN_ADD,
        S_FIN_PAD,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic item_ok;
        logic div_done;
        logic scan_done;
        logic ren_done;
        logic ren_emits;
        logic emit_done;
        logic can_push;
        logic can_pad;
        logic bits_zero;
        logic hold_v;
        logic out_free;
    } t_status;

    // Decide one renormalize step from the current interval ends.
    function automatic t_step classify(input logic [31:0] lo, input logic [31:0] hi);
        t_step s;
        if (hi < HALF_MARK) begin
            s = STEP_ZERO;
        end else if (lo >= HALF_MARK) begin
            s = STEP_ONE;
        end else if (lo >= QUARTER_MARK && hi < THREE_QUARTER) begin
            s = STEP_MID;
        end else begin
            s = STEP_STOP;
        end
        return s;
    endfunction

endpackage

FILE: design/arenc_ctrl.sv
// Controller state machine of the arithmetic encoder core.
// Depends on arenc_pkg; drives datapath commands from datapath status.
module arenc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_op,
    output logic               o_stall,
    input  arenc_pkg::t_status i_st,
    output arenc_pkg::t_cmd    o_cmd
);

    arenc_pkg::t_state r_state, n_state;
    logic r_fin, n_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arenc_pkg::S_IDLE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        o_cmd   = arenc_pkg::CMD_NONE;
        o_stall = 1'b1;
        case (r_state)
            arenc_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd   = arenc_pkg::CMD_LOAD;
                    n_fin   = i_op;
                    n_state = i_op ? arenc_pkg::S_FIN_ADD : arenc_pkg::S_CHECK;
                end
            end
            arenc_pkg::S_CHECK: begin
                if (!i_st.item_ok) begin
                    n_state = arenc_pkg::S_IDLE;
                end else begin
                    o_cmd   = arenc_pkg::CMD_MUL_HI;
                    n_state = arenc_pkg::S_DIV_HI;
                end
            end
            arenc_pkg::S_DIV_HI: begin
                if (!i_st.div_done) begin
                    o_cmd = arenc_pkg::CMD_DIV_STEP;
                end else begin
                    o_cmd   = arenc_pkg::CMD_MUL_LO;
                    n_state = arenc_pkg::S_DIV_LO;
                end
            end
            arenc_pkg::S_DIV_LO: begin
                if (!i_st.div_done) begin
                    o_cmd = arenc_pkg::CMD_DIV_STEP;
                end else begin
                    o_cmd   = arenc_pkg::CMD_SET_IV;
                    n_state = arenc_pkg::S_SCAN;
                end
            end
            arenc_pkg::S_SCAN: begin
                if (i_st.scan_done) begin
                    o_cmd   = arenc_pkg::CMD_REN_INIT;
                    n_state = arenc_pkg::S_REN;
                end else begin
                    o_cmd = arenc_pkg::CMD_SCAN_STEP;
                end
            end
            arenc_pkg::S_REN: begin
                if (i_st.ren_done) begin
                    n_state = arenc_pkg::S_DRAIN;
                end else begin
                    o_cmd = arenc_pkg::CMD_REN_STEP;
                    if (i_st.ren_emits) begin
                        n_state = arenc_pkg::S_EMIT;
                    end
                end
            end
            arenc_pkg::S_EMIT: begin
                if (i_st.emit_done) begin
                    n_state = r_fin ? arenc_pkg::S_FIN_PAD : arenc_pkg::S_REN;
                end else if (i_st.can_push) begin
                    o_cmd = arenc_pkg::CMD_PUSH;
                end
            end
            arenc_pkg::S_FIN_ADD: begin
                o_cmd   = arenc_pkg::CMD_FIN_ADD;
                n_state = arenc_pkg::S_EMIT;
            end
            arenc_pkg::S_FIN_PAD: begin
                if (i_st.bits_zero) begin
                    o_cmd   = arenc_pkg::CMD_FIN_INIT;
                    n_state = arenc_pkg::S_DRAIN;
                end else if (i_st.can_pad) begin
                    o_cmd = arenc_pkg::CMD_PAD;
                end
            end
            arenc_pkg::S_DRAIN: begin
                if (!i_st.hold_v) begin
                    n_state = arenc_pkg::S_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd   = arenc_pkg::CMD_DRAIN;
                    n_state = arenc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = arenc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/arenc_dp.sv
// Datapath of the arithmetic encoder core: interval, divider, bit packer and output stage.
// Depends on arenc_pkg and arithmetic_encoder_core_macros.svh; commanded by arenc_ctrl.
`include "arithmetic_encoder_core_macros.svh"

module arenc_dp #(
    parameter int FREQ_BITS   = arenc_pkg::FREQ_BITS,
    parameter int PENDING_MAX = arenc_pkg::PENDING_MAX
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  arenc_pkg::t_cmd    i_cmd,
    input  logic [15:0]        i_cum_low,
    input  logic [16:0]        i_cum_high,
    input  logic [16:0]        i_total,
    input  logic               i_stall,
    output arenc_pkg::t_status o_st,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last,
    output logic               o_overflow
);

    localparam logic [24:0] TOT_LIMIT = 25'(64'd1 << FREQ_BITS);
    localparam logic [arenc_pkg::PEND_W-1:0] PEND_LIMIT = arenc_pkg::PEND_W'(PENDING_MAX);

    logic [31:0] r_lo, r_hi, r_slo, r_shi, r_range, r_qhi;
    logic [arenc_pkg::PEND_W-1:0] r_pend, r_spend;
    logic [7:0]  r_bs, r_hold;
    logic [2:0]  r_bits;
    logic        r_flag, r_hold_v, r_ebit, r_first;
    logic [15:0] r_cl;
    logic [16:0] r_ch, r_tot;
    logic [arenc_pkg::PROD_W-1:0] r_dvd;
    logic [17:0] r_rem;
    logic [arenc_pkg::DCNT_W-1:0] r_dcnt;
    logic [arenc_pkg::RCNT_W-1:0] r_rcnt;
    logic        r_out_v, r_out_last, r_out_ovf;
    logic [7:0]  r_out_byte;

    arenc_pkg::t_step scan_step, ren_step;
    logic        out_free, push_bit, out_load;
    logic [7:0]  push_byte, pad_byte;
    logic [17:0] rem_try;
    logic [31:0] slo_n, shi_n, lo_n, hi_n;
    logic        pend_in_range, drain_ok, fin_init, fin_clean;

    assign scan_step = arenc_pkg::classify(r_slo, r_shi);
    assign ren_step  = arenc_pkg::classify(r_lo, r_hi);
    assign out_free  = !r_out_v || !i_stall;
    assign push_bit  = r_first ? r_ebit : !r_ebit;
    assign push_byte = {r_bs[6:0], push_bit};
    assign pad_byte  = 8'(r_bs << (4'd8 - {1'b0, r_bits}));
    assign rem_try   = {r_rem[16:0], r_dvd[arenc_pkg::PROD_W-1]};

    // A byte moves from the hold stage into the output register on these commands.
    assign out_load  = (i_cmd == arenc_pkg::CMD_DRAIN)
                       || (r_hold_v && (((i_cmd == arenc_pkg::CMD_PUSH) && (r_bits == 3'd7))
                                        || (i_cmd == arenc_pkg::CMD_PAD)));

    always_comb begin
        slo_n = r_slo;
        shi_n = r_shi;
        if (scan_step == arenc_pkg::STEP_ONE) begin
            slo_n = r_slo - arenc_pkg::HALF_MARK;
            shi_n = r_shi - arenc_pkg::HALF_MARK;
        end else if (scan_step == arenc_pkg::STEP_MID) begin
            slo_n = r_slo - arenc_pkg::QUARTER_MARK;
            shi_n = r_shi - arenc_pkg::QUARTER_MARK;
        end
        lo_n = r_lo;
        hi_n = r_hi;
        if (ren_step == arenc_pkg::STEP_ONE) begin
            lo_n = r_lo - arenc_pkg::HALF_MARK;
            hi_n = r_hi - arenc_pkg::HALF_MARK;
        end else if (ren_step == arenc_pkg::STEP_MID) begin
            lo_n = r_lo - arenc_pkg::QUARTER_MARK;
            hi_n = r_hi - arenc_pkg::QUARTER_MARK;
        end
    end

    always_comb begin
        o_st.item_ok   = (r_tot != 17'd0) && ({8'd0, r_tot} <= TOT_LIMIT)
                         && (r_ch <= r_tot) && ({1'b0, r_cl} < r_ch);
        o_st.div_done  = (r_dcnt == arenc_pkg::DCNT_W'(arenc_pkg::DIV_STEPS));
        o_st.scan_done = (scan_step == arenc_pkg::STEP_STOP) || r_rcnt[arenc_pkg::RCNT_W-1];
        o_st.ren_done  = (ren_step == arenc_pkg::STEP_STOP) || r_rcnt[arenc_pkg::RCNT_W-1];
        o_st.ren_emits = (ren_step == arenc_pkg::STEP_ZERO) || (ren_step == arenc_pkg::STEP_ONE);
        o_st.emit_done = !r_first && (r_pend == '0);
        o_st.can_push  = !((r_bits == 3'd7) && r_hold_v && !out_free);
        o_st.can_pad   = !(r_hold_v && !out_free);
        o_st.bits_zero = (r_bits == 3'd0);
        o_st.hold_v    = r_hold_v;
        o_st.out_free  = out_free;
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            arenc_pkg::CMD_LOAD: begin
                r_cl    <= i_cum_low;
                r_ch    <= i_cum_high;
                r_tot   <= i_total;
                r_range <= r_hi - r_lo;
            end
            arenc_pkg::CMD_MUL_HI: begin
                r_dvd <= r_range * r_ch;
                r_rem <= '0;
            end
            arenc_pkg::CMD_MUL_LO: begin
                r_qhi <= r_dvd[31:0];
                r_dvd <= r_range * {1'b0, r_cl};
                r_rem <= '0;
            end
            arenc_pkg::CMD_DIV_STEP: begin
                if (rem_try >= {1'b0, r_tot}) begin
                    r_rem <= rem_try - {1'b0, r_tot};
                    r_dvd <= {r_dvd[arenc_pkg::PROD_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_try;
                    r_dvd <= {r_dvd[arenc_pkg::PROD_W-2:0], 1'b0};
                end
            end
            arenc_pkg::CMD_SET_IV: begin
                r_slo   <= r_lo + r_dvd[31:0];
                r_shi   <= r_lo + r_qhi;
                r_spend <= r_pend;
            end
            arenc_pkg::CMD_SCAN_STEP: begin
                r_slo <= {slo_n[30:0], 1'b0};
                r_shi <= {shi_n[30:0], 1'b0};
                if (scan_step == arenc_pkg::STEP_MID) begin
                    if (r_spend < PEND_LIMIT) begin
                        r_spend <= r_spend + 1'b1;
                    end
                end else begin
                    r_spend <= '0;
                end
            end
            arenc_pkg::CMD_REN_STEP: begin
                r_ebit <= (ren_step == arenc_pkg::STEP_ONE);
            end
            arenc_pkg::CMD_FIN_ADD: begin
                r_ebit <= (r_lo >= arenc_pkg::QUARTER_MARK);
            end
            default: begin
            end
        endcase
    end

    // Architectural state, counters and the byte path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo     <= '0;
            r_hi     <= arenc_pkg::FULL_TOP;
            r_pend   <= '0;
            r_bs     <= '0;
            r_bits   <= '0;
            r_flag   <= 1'b0;
            r_hold_v <= 1'b0;
            r_first  <= 1'b0;
            r_out_v  <= 1'b0;
            r_dcnt   <= '0;
            r_rcnt   <= '0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
            case (i_cmd)
                arenc_pkg::CMD_MUL_HI, arenc_pkg::CMD_MUL_LO: begin
                    r_dcnt <= '0;
                end
                arenc_pkg::CMD_DIV_STEP: begin
                    r_dcnt <= r_dcnt + 1'b1;
                end
                arenc_pkg::CMD_SET_IV: begin
                    r_hi   <= r_lo + r_qhi;
                    r_lo   <= r_lo + r_dvd[31:0];
                    r_rcnt <= '0;
                end
                arenc_pkg::CMD_SCAN_STEP: begin
                    r_rcnt <= r_rcnt + 1'b1;
                    if (scan_step == arenc_pkg::STEP_MID && r_spend >= PEND_LIMIT) begin
                        r_flag <= 1'b1;
                    end
                end
                arenc_pkg::CMD_REN_INIT: begin
                    r_rcnt <= '0;
                end
                arenc_pkg::CMD_REN_STEP: begin
                    r_rcnt <= r_rcnt + 1'b1;
                    r_lo   <= {lo_n[30:0], 1'b0};
                    r_hi   <= {hi_n[30:0], 1'b0};
                    if (ren_step == arenc_pkg::STEP_MID) begin
                        if (r_pend < PEND_LIMIT) begin
                            r_pend <= r_pend + 1'b1;
                        end
                    end else begin
                        r_first <= 1'b1;
                    end
                end
                arenc_pkg::CMD_FIN_ADD: begin
                    r_first <= 1'b1;
                    if (r_pend >= PEND_LIMIT) begin
                        r_flag <= 1'b1;
                    end else begin
                        r_pend <= r_pend + 1'b1;
                    end
                end
                arenc_pkg::CMD_PUSH: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                    end else begin
                        r_pend <= r_pend - 1'b1;
                    end
                    if (r_bits == 3'd7) begin
                        r_bs     <= '0;
                        r_bits   <= '0;
                        r_hold   <= push_byte;
                        r_hold_v <= 1'b1;
                        if (r_hold_v) begin
                            r_out_byte <= r_hold;
                            r_out_last <= 1'b0;
                            r_out_ovf  <= r_flag;
                        end
                    end else begin
                        r_bs   <= push_byte;
                        r_bits <= r_bits + 1'b1;
                    end
                end
                arenc_pkg::CMD_PAD: begin
                    r_bs     <= '0;
                    r_bits   <= '0;
                    r_hold   <= pad_byte;
                    r_hold_v <= 1'b1;
                    if (r_hold_v) begin
                        r_out_byte <= r_hold;
                        r_out_last <= 1'b0;
                        r_out_ovf  <= r_flag;
                    end
                end
                arenc_pkg::CMD_FIN_INIT: begin
                    r_lo   <= '0;
                    r_hi   <= arenc_pkg::FULL_TOP;
                    r_pend <= '0;
                    r_bs   <= '0;
                    r_bits <= '0;
                end
                arenc_pkg::CMD_DRAIN: begin
                    r_hold_v   <= 1'b0;
                    r_out_byte <= r_hold;
                    r_out_last <= 1'b1;
                    r_out_ovf  <= r_flag;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid    = r_out_v;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;
    assign o_overflow = r_out_ovf;

    assign pend_in_range = (r_pend <= PEND_LIMIT);
    assign drain_ok      = (i_cmd != arenc_pkg::CMD_DRAIN) || out_free;
    assign fin_init      = (i_cmd == arenc_pkg::CMD_FIN_INIT);
    assign fin_clean     = (r_bits == 3'd0) && (r_lo == '0) && (r_pend == '0);

    `ARENC_ASSERT(a_pend_limit, pend_in_range, "pending count above its limit")
    `ARENC_ASSERT(a_drain_free, drain_ok, "drain into a blocked output stage")
    `ARENC_ASSERT_NEXT(a_fin_clear, fin_init, fin_clean, "finish left coder state behind")
    `ARENC_ASSERT_NEXT(a_flag_sticky, r_flag, r_flag, "overflow flag cleared without reset")

endmodule

FILE: design/arithmetic_encoder_core.sv
// Top level of the 32-bit arithmetic encoder core.
// Depends on arenc_pkg, arenc_ctrl and arenc_dp.

// The block takes one transaction at a time. An encode transaction carries the symbol's
// cumulative interval and the model total; the block narrows the coding interval with two
// products that are each divided by the total in a one-bit-per-cycle restoring divider,
// then renormalizes. Renormalization runs twice: a first pass of up to 64 steps only
// tracks the pending underflow count so that the sticky overflow flag is final before any
// byte leaves, and a second pass of up to 64 steps moves the interval and emits bits at
// one bit per cycle while the output side does not stall a full output stage, so an
// emitted bit is followed by each of its pending bits in turn.
// Bytes leave through a one-entry output register after a one-byte hold stage, so the last
// byte of each transaction can be marked; the overflow field reports the flag as it stands
// after the whole transaction. An invalid symbol (zero total, total above the model limit,
// cum_high above total, or cum_low not below cum_high) is dropped without results.
module arithmetic_encoder_core #(
    parameter int FREQ_BITS   = arenc_pkg::FREQ_BITS,
    parameter int PENDING_MAX = arenc_pkg::PENDING_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [15:0] i_cum_low,
    input  logic [16:0] i_cum_high,
    input  logic [16:0] i_total,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_overflow
);

    arenc_pkg::t_cmd    cmd;
    arenc_pkg::t_status st;

    arenc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    arenc_dp #(
        .FREQ_BITS   (FREQ_BITS),
        .PENDING_MAX (PENDING_MAX)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cum_low  (i_cum_low),
        .i_cum_high (i_cum_high),
        .i_total    (i_total),
        .i_stall    (i_stall),
        .o_st       (st),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .o_overflow (o_overflow)
    );

endmodule

FILE: verif/arithmetic_encoder_core_checker.sv
// Scoreboard for the arithmetic encoder core: watches both channels, predicts the code bytes
// and compares them. Depends on arenc_pkg for the interval constants and limits.
module arithmetic_encoder_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall,
    input  logic        i_op,
    input  logic [15:0] i_cum_low,
    input  logic [16:0] i_cum_high,
    input  logic [16:0] i_total,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    input  logic        i_out_overflow,
    output int          o_errors,
    output int          o_pending_bytes
);

    localparam logic OP_ENCODE = 1'b0;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       ovf;
    } t_byte;

    t_byte       byte_q[$];
    logic [31:0] iv_low, iv_high;
    int unsigned pend;
    logic [7:0]  shreg;
    int unsigned nbits;
    logic        ovf_flag;
    logic [7:0]  made[$];

    assign o_pending_bytes = byte_q.size();

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic void put_bit(input logic b);
        shreg = {shreg[6:0], b};
        nbits++;
        if (nbits == 8) begin
            made.push_back(shreg);
            shreg = '0;
            nbits = 0;
        end
    endfunction

    function automatic void emit_bit(input logic b);
        put_bit(b);
        while (pend != 0) begin
            put_bit(!b);
            pend--;
        end
    endfunction

    function automatic void count_underflow();
        if (pend >= arenc_pkg::PENDING_MAX) ovf_flag = 1'b1;
        else pend++;
    endfunction

    function automatic void clear_interval();
        iv_low = '0;
        iv_high = arenc_pkg::FULL_TOP;
        pend = 0;
        shreg = '0;
        nbits = 0;
    endfunction

    function automatic void encode_item(input logic op, input logic [15:0] cl,
                                        input logic [16:0] ch, input logic [16:0] tot);
        logic [63:0] span, lo, hi;
        made.delete();
        if (op == OP_ENCODE) begin
            if (tot == 0 || tot > (1 << arenc_pkg::FREQ_BITS) || ch > tot || cl >= ch) return;
            lo = iv_low;
            hi = iv_high;
            span = hi - lo;
            hi = lo + (span * ch) / tot;
            lo = lo + (span * cl) / tot;
            for (int g = 0; g < 64; g++) begin
                if (hi < arenc_pkg::HALF_MARK) begin
                    emit_bit(1'b0);
                end else if (lo >= arenc_pkg::HALF_MARK) begin
                    emit_bit(1'b1);
                    lo -= arenc_pkg::HALF_MARK;
                    hi -= arenc_pkg::HALF_MARK;
                end else if (lo >= arenc_pkg::QUARTER_MARK &&
                             hi < arenc_pkg::THREE_QUARTER) begin
                    count_underflow();
                    lo -= arenc_pkg::QUARTER_MARK;
                    hi -= arenc_pkg::QUARTER_MARK;
                end else begin
                    break;
                end
                lo = (lo << 1) & 64'hFFFF_FFFF;
                hi = (hi << 1) & 64'hFFFF_FFFF;
            end
            iv_low = lo[31:0];
            iv_high = hi[31:0];
        end else begin
            count_underflow();
            emit_bit(iv_low >= arenc_pkg::QUARTER_MARK);
            if (nbits != 0) made.push_back(shreg << (8 - nbits));
            clear_interval();
        end
        foreach (made[k]) byte_q.push_back('{made[k], k == made.size() - 1, ovf_flag});
    endfunction

    initial begin
        o_errors = 0;
        ovf_flag = 1'b0;
        clear_interval();
    end

    always @(posedge i_clk) begin
        t_byte want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (byte_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", i_out_byte));
                end else begin
                    want = byte_q.pop_front();
                    if (i_out_byte !== want.code)
                        report_mismatch($sformatf("byte %02h, want %02h", i_out_byte,
                                                  want.code));
                    if (i_out_last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", i_out_last, want.last));
                    if (i_out_overflow !== want.ovf)
                        report_mismatch($sformatf("overflow %b, want %b", i_out_overflow,
                                                  want.ovf));
                end
            end
            if (i_valid && !i_stall) encode_item(i_op, i_cum_low, i_cum_high, i_total);
        end
    end
endmodule

FILE: verif/arithmetic_encoder_core_tb.sv
// Testbench top for the arithmetic encoder core: clock, reset, stimulus and verdict.
// Depends on arithmetic_encoder_core and arithmetic_encoder_core_checker.
module arithmetic_encoder_core_tb;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        sym_valid;
    logic        sym_stall;
    logic        sym_op;
    logic [15:0] sym_cum_low;
    logic [16:0] sym_cum_high;
    logic [16:0] sym_total;
    logic        code_valid;
    logic        code_stall;
    logic [7:0]  code_byte;
    logic        code_last;
    logic        code_ovf;
    int          fail_count;
    int          bytes_owed;
    bit          calm;

    arithmetic_encoder_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (sym_valid),
        .o_stall    (sym_stall),
        .i_op       (sym_op),
        .i_cum_low  (sym_cum_low),
        .i_cum_high (sym_cum_high),
        .i_total    (sym_total),
        .o_valid    (code_valid),
        .i_stall    (code_stall),
        .o_out_byte (code_byte),
        .o_last     (code_last),
        .o_overflow (code_ovf)
    );

    arithmetic_encoder_core_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (sym_valid),
        .i_stall         (sym_stall),
        .i_op            (sym_op),
        .i_cum_low       (sym_cum_low),
        .i_cum_high      (sym_cum_high),
        .i_total         (sym_total),
        .i_out_valid     (code_valid),
        .i_out_stall     (code_stall),
        .i_out_byte      (code_byte),
        .i_out_last      (code_last),
        .i_out_overflow  (code_ovf),
        .o_errors        (fail_count),
        .o_pending_bytes (bytes_owed)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // The output side stalls in random bursts until the final calm stretch.
    initial begin
        code_stall = 1'b0;
        forever begin
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                code_stall = 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                code_stall = 1'b0;
            end
        end
    end

    // One transaction: present it at a falling edge, hold it until a rising edge accepts it,
    // and then maybe leave a gap. Valid is only dropped when a gap follows.
    task automatic send_item(input logic op, input logic [15:0] cl, input logic [16:0] ch,
                             input logic [16:0] tot);
        sym_op = op;
        sym_cum_low = cl;
        sym_cum_high = ch;
        sym_total = tot;
        sym_valid = 1'b1;
        do @(posedge i_clk); while (sym_stall);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            sym_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    task automatic send_symbol(input logic [16:0] tot, input logic [16:0] lo_c,
                               input logic [16:0] hi_c);
        send_item(OP_ENCODE, lo_c[15:0], hi_c, tot);
    endtask

    // A narrow symbol placed across the middle of the current interval; each one adds a
    // dozen or more underflows and emits nothing.
    task automatic centered_symbol();
        logic [63:0] span, x, cl;
        span = 64'(u_checker.iv_high) - 64'(u_checker.iv_low);
        x = ((64'h8000_0000 - 64'(u_checker.iv_low)) << 16) / span;
        cl = (x == 64'd0) ? 64'd0 : x - 64'd1;
        if (cl > 64'd65533) cl = 64'd65533;
        send_symbol(17'h10000, cl[16:0], cl[16:0] + 17'd3);
    endtask

    // A random well-formed symbol; skewed totals give both wide and very narrow intervals.
    task automatic random_symbol();
        logic [16:0] tot, a, b;
        case ($urandom_range(0, 3))
            0: tot = 17'h10000;
            1: tot = 17'($urandom_range(1, 16));
            default: tot = 17'($urandom_range(1, 17'h10000));
        endcase
        a = 17'($urandom_range(0, tot - 1));
        b = (tot - a == 1 || $urandom_range(0, 1)) ? a + 17'd1
                                                   : 17'($urandom_range(a + 1, tot));
        send_symbol(tot, a, b);
    endtask

    // Items the block must ignore: each breaks one of the symbol rules.
    task automatic broken_symbol();
        logic [16:0] t;
        t = 17'($urandom_range(2, 17'h10000));
        case ($urandom_range(0, 3))
            0: send_item(OP_ENCODE, 16'($urandom), 17'($urandom), 17'd0);
            1: send_item(OP_ENCODE, 16'd0, 17'd1, 17'($urandom_range(17'h10001, 17'h1FFFF)));
            2: send_item(OP_ENCODE, 16'd0, t + 17'd1, t);
            default: send_item(OP_ENCODE, 16'hFFFF, 17'($urandom_range(1, 16'hFFFF)),
                               17'h10000);
        endcase
    endtask

    task automatic wait_drained();
        sym_valid = 1'b0;
        while (bytes_owed != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    initial begin
        calm = 1'b0;
        sym_valid = 1'b0;
        sym_op = OP_ENCODE;
        sym_cum_low = '0;
        sym_cum_high = 17'd1;
        sym_total = 17'd1;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes of the fields, a finish on a fresh interval, invalid symbols.
        send_item(OP_FINISH, 16'hFFFF, 17'h1FFFF, 17'h1FFFF);
        send_symbol(17'h10000, 17'd0, 17'd1);
        send_symbol(17'h10000, 17'hFFFF, 17'h10000);
        send_symbol(17'h10000, 17'd0, 17'h10000);
        send_symbol(17'd1, 17'd0, 17'd1);
        send_symbol(17'd3, 17'd1, 17'd2);
        send_item(OP_FINISH, 16'd0, 17'd0, 17'd0);
        send_symbol(17'd4, 17'd1, 17'd3);
        send_item(OP_FINISH, 16'h5A5A, 17'h0A5A5, 17'h1A5A5);
        send_item(OP_ENCODE, 16'd0, 17'd0, 17'd0);
        send_item(OP_ENCODE, 16'd0, 17'd1, 17'h10001);
        send_item(OP_ENCODE, 16'd5, 17'd9, 17'd8);
        send_item(OP_ENCODE, 16'd7, 17'd7, 17'd8);
        send_item(OP_ENCODE, 16'hFFFF, 17'h1FFFF, 17'h1FFFF);

        // Hold off until every byte is out so the pipeline is seen draining empty.
        wait_drained();

        // Middle-half symbols pile up underflows past the saturation limit.
        repeat (40) centered_symbol();
        send_symbol(17'd2, 17'd0, 17'd1);
        send_item(OP_FINISH, 16'd0, 17'd0, 17'd1);

        for (int n = 0; n < 160; n++) begin
            if (n == 130) calm = 1'b1;
            case ($urandom_range(0, 19))
                0:       send_item(OP_FINISH, 16'($urandom), 17'($urandom), 17'($urandom));
                1:       broken_symbol();
                default: random_symbol();
            endcase
        end
        send_item(OP_FINISH, 16'd0, 17'd0, 17'd1);
        sym_valid = 1'b0;

        while (bytes_owed != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("arithmetic_encoder_core regression: pass");
        end else begin
            $display("arithmetic_encoder_core regression: fail");
        end
        $finish;
    end

    // Watchdog: generous bound over the slowest legal run.
    initial begin
        #8000000;
        $display("arithmetic_encoder_core regression: fail");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+design
design/arenc_pkg.sv
design/arenc_ctrl.sv
design/arenc_dp.sv
design/arithmetic_encoder_core.sv
verif/arithmetic_encoder_core_checker.sv
verif/arithmetic_encoder_core_tb.sv
